[hw/rtl/lru_kv_pkg.sv]
// shared constants and types for the lru key-value cache
package lru_kv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } lookup_t;

endpackage

[hw/rtl/lru_kv_match.sv]
// parallel key compare against the tag array, gives hit and index
module lru_kv_match
(
    input  logic [lru_kv_pkg::ENTRIES-1:0]                        valid,
    input  logic [lru_kv_pkg::ENTRIES-1:0][lru_kv_pkg::KEY_W-1:0] keys,
    input  logic [lru_kv_pkg::KEY_W-1:0]                          key,
    output lru_kv_pkg::lookup_t                                   result
);
    import lru_kv_pkg::*;

    always_comb
    begin
        result = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid[i] && keys[i] == key)
            begin
                result.hit = 1'b1;
                result.idx = IDX_W'(i);
            end
        end
    end
endmodule

[hw/rtl/lru_key_value_cache.sv]
// top level of the lru key-value cache
// In each transaction the key is first compared against all tags in
// flip-flops while the value memory (one synchronous port, registered
// read) is read at the matching slot, then the result is registered and
// the memory written back. One request is in flight at a time; the next is
// accepted once the result register is free or being taken. Recency is held
// as a rank per entry; entries are cleared at reset through valid bits.
module lru_key_value_cache
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // key[31:0], value[63:32]
    input  logic        s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // value_out
    output logic        m_axis_tuser,  // found
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata
);
    import lru_kv_pkg::*;

    logic [CAP_W-1:0]                   cap_reg;
    logic [ENTRIES-1:0]                 valid_reg;
    logic [ENTRIES-1:0][KEY_W-1:0]      keys_reg;
    logic [ENTRIES-1:0][IDX_W-1:0]      rank_reg;
    logic [CNT_W-1:0]                   count_reg;
    logic [VAL_W-1:0]                   val_mem [ENTRIES];
    logic [VAL_W-1:0]                   rd_data_reg;

    logic                               busy_reg;
    logic                               cmd_reg;
    logic [KEY_W-1:0]                   key_reg;
    logic [VAL_W-1:0]                   val_reg;
    lookup_t                            look_reg;

    logic                               out_valid_reg;
    logic                               out_found_reg;
    logic [VAL_W-1:0]                   out_value_reg;

    lookup_t                            look;
    logic [CNT_W-1:0]                   cap_eff;
    logic [ENTRIES-1:0]                 keep;
    logic [ENTRIES-1:0]                 valid_next;
    logic [ENTRIES-1:0][IDX_W-1:0]      rank_next;
    logic [CNT_W-1:0]                   count_next;
    logic [IDX_W-1:0]                   slot;
    logic                               slot_ok;
    logic                               accept;
    logic                               out_free;

    lru_kv_match u_match
    (
        .valid  (valid_reg),
        .keys   (keys_reg),
        .key    (s_axis_tdata[KEY_W-1:0]),
        .result (look)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !busy_reg && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_found_reg;

    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = CNT_W'(1);
        else if (32'(cap_reg) > ENTRIES)
            cap_eff = CNT_W'(ENTRIES);
        else
            cap_eff = CNT_W'(cap_reg);
    end

    // rank and valid update for the request held while busy
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        count_next = count_reg;
        keep       = valid_reg;
        slot       = '0;
        slot_ok    = 1'b0;
        if (look_reg.hit)
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (valid_reg[i] && rank_reg[i] < rank_reg[look_reg.idx])
                    rank_next[i] = rank_reg[i] + 1'b1;
            rank_next[look_reg.idx] = '0;
        end
        else if (cmd_reg == CMD_PUT)
        begin
            if (count_reg >= cap_eff)
                for (int i = 0; i < ENTRIES; i++)
                    if (valid_reg[i] && CNT_W'(rank_reg[i]) >= cap_eff - 1'b1)
                        keep[i] = 1'b0;
            count_next = '0;
            for (int i = ENTRIES - 1; i >= 0; i--)
            begin
                if (!keep[i])
                begin
                    slot    = IDX_W'(i);
                    slot_ok = 1'b1;
                end
            end
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (keep[i])
                begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                    count_next   = count_next + 1'b1;
                end
                else
                    rank_next[i] = '0;
            end
            valid_next = keep;
            if (slot_ok)
            begin
                valid_next[slot] = 1'b1;
                count_next       = count_next + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= val_mem[look.idx];
        if (busy_reg && cmd_reg == CMD_PUT)
        begin
            if (look_reg.hit)
                val_mem[look_reg.idx] <= val_reg;
            else if (slot_ok)
                val_mem[slot] <= val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= s_axis_tuser;
            key_reg  <= s_axis_tdata[KEY_W-1:0];
            val_reg  <= s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
            look_reg <= look;
        end
        if (busy_reg && cmd_reg == CMD_PUT && !look_reg.hit && slot_ok)
            keys_reg[slot] <= key_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_W'(ENTRIES);
            valid_reg     <= '0;
            rank_reg      <= '0;
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_value_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            if (accept)
                busy_reg <= 1'b1;
            else if (busy_reg)
            begin
                busy_reg      <= 1'b0;
                valid_reg     <= valid_next;
                rank_reg      <= rank_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
                out_found_reg <= look_reg.hit;
                if (cmd_reg == CMD_PUT)
                    out_value_reg <= '0;
                else if (look_reg.hit)
                    out_value_reg <= rd_data_reg;
                else
                    out_value_reg <= '1;
            end
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !s_axis_tready)
        else $error("request accepted while busy");
    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> !busy_reg && out_valid_reg)
        else $error("request did not complete");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= ENTRIES)
        else $error("entry count overflow");
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> 32'(count_reg) == $countones(valid_reg))
        else $error("entry count out of step with valid bits");
endmodule
